// File: src/i2cbb_pkg.sv
`timescale 1ns / 1ps

package i2cbb_pkg;

   // Command codes carried in the cmd field; the idle code doubles as the
   // "no command in progress" marker of the engine.
   localparam logic [2:0] CmdStart = 3'd0;
   localparam logic [2:0] CmdStop  = 3'd1;
   localparam logic [2:0] CmdWrite = 3'd2;
   localparam logic [2:0] CmdRead  = 3'd3;
   localparam logic [2:0] CmdMack  = 3'd4;
   localparam logic [2:0] CmdMnack = 3'd5;
   localparam logic [2:0] CmdSack  = 3'd6;
   localparam logic [2:0] CmdIdle  = 3'd7;

   localparam int unsigned CounterWidthDefault = 16;
   localparam int unsigned PhaseTicksWidth     = 16;
   localparam logic [PhaseTicksWidth-1:0] PhaseTicksReset = 16'd400;

   // Last phase index of a bit, bits per byte command and bits per single-bit command.
   localparam logic [1:0] LastPhase = 2'd2;
   localparam logic [3:0] ByteBits  = 4'd8;
   localparam logic [3:0] SingleBit = 4'd1;

   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] cmd;
      logic [7:0] tx_byte;
      logic       sda_in;
   } req_payload_type;

endpackage

// File: src/i2cbb_if.sv
`timescale 1ns / 1ps

interface i2cbb_req_if;
   logic       valid;
   logic       ready;
   logic       cmd_valid;
   logic [2:0] cmd;
   logic [7:0] tx_byte;
   logic       sda_in;

   modport source (output valid, cmd_valid, cmd, tx_byte, sda_in, input ready);
   modport sink (input valid, cmd_valid, cmd, tx_byte, sda_in, output ready);
endinterface

interface i2cbb_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_out;
   logic       sda_out;
   logic       busy_res;
   logic       done_res;
   logic [7:0] rx_byte;

   modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte,
                   input ready);
   modport sink (input valid, scl_out, sda_out, busy_res, done_res, rx_byte,
                 output ready);
endinterface

// File: src/i2c_bitbang_master.sv
`timescale 1ns / 1ps

// Tick-level I2C master. Every transfer on the request channel is one clock tick
// of the bus timing and may carry a command (start, stop, write byte, read byte,
// master ACK, master NACK, slave-ACK clock); every accepted tick produces exactly
// one response transfer with the SCL and SDA levels, busy and done flags and the
// last received byte. Each pin phase lasts csr_phase_ticks ticks (zero counts as
// one), bytes go MSB first in three phases per bit, and commands arriving while
// busy are dropped. One tick is accepted every clock cycle unless the response side
// stalls; a tick passes through an input register and then a result register, and
// its response stays on the result ports until the response side takes it.
module i2c_bitbang_master
   import i2cbb_pkg::*;
#(
   parameter int unsigned COUNTER_WIDTH = CounterWidthDefault
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [PhaseTicksWidth-1:0] csr_wr_data,
   i2cbb_req_if.sink                  req_ch,
   i2cbb_rsp_if.source                rsp_ch
);

   localparam logic [31:0] CntMax = 32'((64'd1 << COUNTER_WIDTH) - 64'd1);

   logic [PhaseTicksWidth-1:0] phase_ticks_ff;
   logic [31:0]                ticks_ext;
   logic [31:0]                limit_wide;
   logic [COUNTER_WIDTH-1:0]   phase_limit;
   logic                       item_valid;
   logic                       item_ready;
   req_payload_type            item;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= PhaseTicksReset;
      end else if (csr_wr_en) begin
         phase_ticks_ff <= csr_wr_data;
      end
   end

   // A zero setting counts as one; a narrow counter saturates the limit.
   always_comb begin
      ticks_ext  = 32'(phase_ticks_ff);
      limit_wide = (ticks_ext == 32'd0) ? 32'd1 : ticks_ext;
      if (limit_wide > CntMax) limit_wide = CntMax;
   end

   assign phase_limit = limit_wide[COUNTER_WIDTH-1:0];

   i2cbb_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   i2cbb_engine #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item_ready  (item_ready),
      .item        (item),
      .phase_limit (phase_limit),
      .rsp_ch      (rsp_ch)
   );

endmodule

// File: src/i2cbb_in_stage.sv
`timescale 1ns / 1ps

module i2cbb_in_stage
   import i2cbb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   i2cbb_req_if.sink       req_ch,
   output logic            item_valid,
   input  logic            item_ready,
   output req_payload_type item
);

   logic            valid_ff;
   req_payload_type data_ff;
   logic            take;

   assign req_ch.ready = !valid_ff || item_ready;
   assign take         = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= 1'b1;
      end else if (item_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff.cmd_valid <= req_ch.cmd_valid;
         data_ff.cmd       <= req_ch.cmd;
         data_ff.tx_byte   <= req_ch.tx_byte;
         data_ff.sda_in    <= req_ch.sda_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = data_ff;

endmodule

// File: src/i2cbb_engine.sv
`timescale 1ns / 1ps

module i2cbb_engine
   import i2cbb_pkg::*;
#(
   parameter int unsigned COUNTER_WIDTH = CounterWidthDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_valid,
   output logic                     item_ready,
   input  req_payload_type          item,
   input  logic [COUNTER_WIDTH-1:0] phase_limit,
   i2cbb_rsp_if.source              rsp_ch
);

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic [7:0] shift;
   } pin_type;

   // Pin levels applied on entry to a phase of the active command.
   function automatic pin_type enter_phase(input logic [2:0] c, input logic [1:0] p,
                                           input pin_type cur);
      pin_type nxt;
      nxt = cur;
      case (c)
         CmdStart: begin
            if (p == 2'd0) nxt.sda = 1'b1;
            else if (p == 2'd1) nxt.scl = 1'b1;
            else nxt.sda = 1'b0;
         end
         CmdStop: begin
            if (p == 2'd0) nxt.sda = 1'b0;
            else if (p == 2'd1) nxt.scl = 1'b1;
            else nxt.sda = 1'b1;
         end
         CmdWrite: begin
            if (p == 2'd0) nxt.sda = cur.shift[7];
            else if (p == 2'd1) nxt.scl = 1'b1;
            else nxt.scl = 1'b0;
         end
         CmdRead: begin
            if (p == 2'd0) begin
               nxt.shift = {cur.shift[6:0], 1'b0};
               nxt.sda   = 1'b1;
               nxt.scl   = 1'b1;
            end else if (p == LastPhase) begin
               nxt.scl = 1'b0;
            end
         end
         CmdMack: begin
            if (p == 2'd0) nxt.sda = 1'b0;
            else if (p == 2'd1) nxt.scl = 1'b1;
            else nxt.scl = 1'b0;
         end
         default: begin
            if (p == 2'd0) nxt.sda = 1'b1;
            else if (p == 2'd1) nxt.scl = 1'b1;
            else nxt.scl = 1'b0;
         end
      endcase
      return nxt;
   endfunction

   logic [2:0]               cmd_ff, cmd_in;
   logic [1:0]               phase_ff, phase_in;
   logic [3:0]               bit_ff, bit_in;
   logic [COUNTER_WIDTH-1:0] tick_ff, tick_in;
   pin_type                  pins_ff, pins_in;
   logic [7:0]               rx_ff, rx_in;
   logic                     done_in;

   logic                     rsp_valid_ff;
   logic                     scl_res_ff, sda_res_ff, busy_res_ff, done_res_ff;
   logic [7:0]               rx_res_ff;

   logic                     step;
   logic [COUNTER_WIDTH-1:0] tick_inc;
   logic [3:0]               bits_needed;

   assign item_ready = !rsp_valid_ff || rsp_ch.ready;
   assign step       = item_valid && item_ready;
   assign tick_inc   = tick_ff + 1'b1;
   assign bits_needed = (cmd_ff == CmdWrite || cmd_ff == CmdRead) ? ByteBits : SingleBit;

   always_comb begin
      cmd_in   = cmd_ff;
      phase_in = phase_ff;
      bit_in   = bit_ff;
      tick_in  = tick_ff;
      pins_in  = pins_ff;
      rx_in    = rx_ff;
      done_in  = 1'b0;
      if (cmd_ff == CmdIdle) begin
         if (item.cmd_valid && item.cmd != CmdIdle) begin
            cmd_in        = item.cmd;
            phase_in      = 2'd0;
            bit_in        = 4'd0;
            tick_in       = '0;
            pins_in.shift = (item.cmd == CmdWrite) ? item.tx_byte : 8'd0;
            pins_in       = enter_phase(item.cmd, 2'd0, pins_in);
         end
      end else if (tick_inc >= phase_limit) begin
         tick_in = '0;
         // A read samples SDA as the SCL high phase ends.
         if (cmd_ff == CmdRead && phase_ff == 2'd0) begin
            pins_in.shift = pins_ff.shift | {7'd0, item.sda_in};
         end
         if (phase_ff == LastPhase) begin
            phase_in = 2'd0;
            if (cmd_ff == CmdWrite) pins_in.shift = {pins_in.shift[6:0], 1'b0};
            bit_in = bit_ff + 4'd1;
            if (bit_in >= bits_needed) begin
               if (cmd_ff == CmdStart) pins_in.scl = 1'b0;
               if (cmd_ff == CmdRead) rx_in = pins_in.shift;
               cmd_in  = CmdIdle;
               bit_in  = 4'd0;
               done_in = 1'b1;
            end else begin
               pins_in = enter_phase(cmd_ff, 2'd0, pins_in);
            end
         end else begin
            phase_in = phase_ff + 2'd1;
            pins_in  = enter_phase(cmd_ff, phase_in, pins_in);
         end
      end else begin
         tick_in = tick_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff        <= CmdIdle;
         phase_ff      <= 2'd0;
         bit_ff        <= 4'd0;
         tick_ff       <= '0;
         pins_ff.scl   <= 1'b1;
         pins_ff.sda   <= 1'b1;
         pins_ff.shift <= 8'd0;
         rx_ff         <= 8'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (step) begin
            cmd_ff   <= cmd_in;
            phase_ff <= phase_in;
            bit_ff   <= bit_in;
            tick_ff  <= tick_in;
            pins_ff  <= pins_in;
            rx_ff    <= rx_in;
         end
         if (step) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         scl_res_ff  <= pins_in.scl;
         sda_res_ff  <= pins_in.sda;
         busy_res_ff <= (cmd_in != CmdIdle);
         done_res_ff <= done_in;
         rx_res_ff   <= rx_in;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.scl_out  = scl_res_ff;
   assign rsp_ch.sda_out  = sda_res_ff;
   assign rsp_ch.busy_res = busy_res_ff;
   assign rsp_ch.done_res = done_res_ff;
   assign rsp_ch.rx_byte  = rx_res_ff;

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_res_ff |-> !busy_res_ff)
      else $error("completion reported while still busy");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3)
      else $error("phase index out of range");

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      cmd_ff == CmdIdle |-> (tick_ff == '0 && phase_ff == 2'd0 && bit_ff == 4'd0))
      else $error("counters not cleared while idle");

   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      cmd_ff != CmdIdle |-> bit_ff < ByteBits)
      else $error("bit count overran a byte");

endmodule
